/* src/ordered_deque_table_macros.svh */
// Assertion macros shared by the checker of the ordered deque table.
// Depends on nothing; included by the files that assert.
`ifndef ORDERED_DEQUE_TABLE_MACROS_SVH
`define ORDERED_DEQUE_TABLE_MACROS_SVH

// Clocked property, ignored while reset is held
`define ODT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset
`define ODT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/odt_pkg.sv */
// Package of the ordered deque table: operation and status codes, beat types.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package odt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_ADD_FRONT  = 3'd0,
    MODE_ADD_BACK   = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_INSERT     = 3'd6,
    MODE_DELETE     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // Which cell the operation lands on: first cell whose own test hits
  typedef enum logic [1:0] {
    MATCH_ALL  = 2'd0,  // front of the list
    MATCH_IDLE = 2'd1,  // first unused cell, i.e. the back
    MATCH_GE   = 2'd2,  // first used cell not smaller than the key, else the first unused cell
    MATCH_EQ   = 2'd3   // first used cell equal to the key
  } match_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD  = 2'd0,
    SHIFT_OPEN  = 2'd1,  // move towards the back, key enters the gap
    SHIFT_CLOSE = 2'd2   // move towards the front over the removed cell
  } shift_t;

  typedef struct packed {
    match_t match;
    shift_t shift;
  } cell_ctrl_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    status_t            status;
    logic [4:0]         entries;
    logic               is_empty;
    logic               is_full;
  } out_beat_t;

endpackage

`default_nettype wire

/* src/odt_cell.sv */
// One cell of the deque chain: holds one word, tests it against the key and
// shifts with its neighbours. Depends on odt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module odt_cell import odt_pkg::*; #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FILL_W     = 5
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire cell_ctrl_t                   ctrl,
  input  wire logic [FILL_W-1:0]            fill,
  input  wire logic signed [DATA_WIDTH-1:0] key,
  input  wire logic signed [DATA_WIDTH-1:0] left_data,
  input  wire logic signed [DATA_WIDTH-1:0] right_data,
  input  wire logic                         hit_in,
  input  wire logic [DATA_WIDTH-1:0]        tail_in,
  output logic signed [DATA_WIDTH-1:0]      data,
  output logic                              hit_out,
  output logic [DATA_WIDTH-1:0]             tail_out
);

  logic signed [DATA_WIDTH-1:0] data_r;
  logic signed [DATA_WIDTH-1:0] data_nxt;
  logic                         active;
  logic                         is_last;
  logic                         hit_here;

  // Position tests against the fill count
  assign active  = (FILL_W+1)'(IDX) < {1'b0, fill};
  assign is_last = {1'b0, fill} == (FILL_W+1)'(IDX + 1);

  // Own test for the landing position
  always_comb begin
    case (ctrl.match)
      MATCH_ALL:  hit_here = 1'b1;
      MATCH_IDLE: hit_here = !active;
      MATCH_GE:   hit_here = !(active && (data_r < key));
      MATCH_EQ:   hit_here = active && (data_r == key);
      default:    hit_here = 1'b0;
    endcase
  end

  assign hit_out  = hit_in | hit_here;
  assign tail_out = is_last ? data_r : tail_in;
  assign data     = data_r;

  // Shift, take the key, or hold
  always_comb begin
    data_nxt = data_r;
    case (ctrl.shift)
      SHIFT_OPEN: begin
        if (hit_in) begin
          data_nxt = left_data;
        end else if (hit_here) begin
          data_nxt = key;
        end
      end
      SHIFT_CLOSE: begin
        if (hit_out) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ordered_deque_table.sv */
// Ordered deque table: a bounded list of signed words, front to back.
// Channels: in_valid/in_ready/in_data carry one operation per beat (mode and
// value); out_valid/out_ready/out_data carry one result beat per operation
// with the value, status, entry count and empty and full flags.
// Operations: add at either end, pop or peek at either end, insert before
// the first entry not smaller than the value, delete the first equal entry.
// Latency: the result is shown the cycle after the operation is taken.
// Throughput: one operation per cycle. Every operation is done by a chain of
// CAPACITY cells that test the key and shift against their neighbours in the
// same cycle, so the ripple of the hit flag along the chain sets the clock.
// The result sits in an output register; while the receiver stalls, a new
// operation is taken only in the cycle that the waiting result leaves.
// Reset (rst_n low at a clock edge) empties the list and drops any result.
// Depends on odt_pkg and odt_cell.
`timescale 1ns / 1ps
`default_nettype none

module ordered_deque_table import odt_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam int FILL_W = $clog2(CAPACITY + 1);

  logic [FILL_W-1:0]            fill_r;
  logic [FILL_W-1:0]            fill_nxt;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  out_beat_t                    out_r;
  out_beat_t                    out_nxt;
  logic                         accept;
  logic                         full;
  logic                         empty;
  cell_ctrl_t                   ctrl;
  logic signed [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH+31:0]       key_ext;
  logic signed [DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH+31:0]       res_ext;
  status_t                      status;
  logic [FILL_W+4:0]            fill_ext;

  logic signed [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]            hit;
  logic [DATA_WIDTH-1:0]        tail [CAPACITY+1];

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign full     = fill_r == FILL_W'(CAPACITY);
  assign empty    = fill_r == '0;

  // Wrap the incoming word to the storage width
  assign key_ext = {{DATA_WIDTH{in_data.value[31]}}, in_data.value};
  assign key     = key_ext[DATA_WIDTH-1:0];

  // Chain of cells
  assign hit[0]  = 1'b0;
  assign tail[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_d;
    logic signed [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = key;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = key;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    odt_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH),
      .FILL_W     (FILL_W)
    ) u_cell (
      .clk        (clk),
      .en         (accept),
      .ctrl       (ctrl),
      .fill       (fill_r),
      .key        (key),
      .left_data  (left_d),
      .right_data (right_d),
      .hit_in     (hit[i]),
      .tail_in    (tail[i]),
      .data       (cell_data[i]),
      .hit_out    (hit[i+1]),
      .tail_out   (tail[i+1])
    );
  end

  // Decode the operation into chain control, result and new count
  always_comb begin
    ctrl.match = MATCH_ALL;
    ctrl.shift = SHIFT_HOLD;
    res        = '0;
    status     = STATUS_OK;
    fill_nxt   = fill_r;
    unique case (in_data.mode)
      MODE_ADD_FRONT, MODE_ADD_BACK, MODE_INSERT: begin
        if (in_data.mode == MODE_ADD_BACK) begin
          ctrl.match = MATCH_IDLE;
        end else if (in_data.mode == MODE_INSERT) begin
          ctrl.match = MATCH_GE;
        end
        if (full) begin
          status = STATUS_FULL;
        end else begin
          ctrl.shift = SHIFT_OPEN;
          fill_nxt   = fill_r + FILL_W'(1);
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (empty) begin
          res    = '1;
          status = STATUS_EMPTY;
        end else begin
          res = cell_data[0];
          if (in_data.mode == MODE_POP_FRONT) begin
            ctrl.shift = SHIFT_CLOSE;
            fill_nxt   = fill_r - FILL_W'(1);
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (empty) begin
          res    = '1;
          status = STATUS_EMPTY;
        end else begin
          res = tail[CAPACITY];
          if (in_data.mode == MODE_POP_BACK) begin
            fill_nxt = fill_r - FILL_W'(1);
          end
        end
      end
      MODE_DELETE: begin
        ctrl.match = MATCH_EQ;
        if (empty) begin
          res    = '1;
          status = STATUS_EMPTY;
        end else if (!hit[CAPACITY]) begin
          status = STATUS_NOT_FOUND;
        end else begin
          res        = key;
          ctrl.shift = SHIFT_CLOSE;
          fill_nxt   = fill_r - FILL_W'(1);
        end
      end
    endcase
  end

  // Form the result beat
  assign res_ext  = {{32{res[DATA_WIDTH-1]}}, res};
  assign fill_ext = {5'b0, fill_nxt};

  always_comb begin
    out_nxt.value_out = res_ext[31:0];
    out_nxt.status    = status;
    out_nxt.entries   = fill_ext[4:0];
    out_nxt.is_empty  = fill_nxt == '0;
    out_nxt.is_full   = fill_nxt == FILL_W'(CAPACITY);
  end

  // Hold the result until taken
  assign out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* src/odt_checker.sv */
// Port checker of the ordered deque table, bound to the top level.
// Depends on odt_pkg and ordered_deque_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_deque_table_macros.svh"

module odt_checker import odt_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);

  // A stalled result beat holds
  `ODT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result beat changed while stalled")

  // Every accepted operation shows a result next cycle
  `ODT_ASSERT(a_in_to_out, in_valid && in_ready |=> out_valid, "accepted beat gave no result")

  // Empty flag agrees with the count
  `ODT_ASSERT(a_empty_flag, out_valid |-> (out_data.is_empty == (out_data.entries == 5'd0)), "empty flag disagrees with count")

  // Empty status returns minus one on an empty list
  `ODT_ASSERT(a_empty_status, out_valid && (out_data.status == STATUS_EMPTY) |-> (out_data.value_out == -32'sd1) && out_data.is_empty, "empty status with wrong value")

  // Reset drops any result
  `ODT_ASSERT_RST(a_reset, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind ordered_deque_table odt_checker u_odt_checker (.*);

`default_nettype wire

/* tb/tb_ordered_deque_table.sv */
// Self-checking testbench of ordered_deque_table: a directed table, then random operations.
// Results are checked against a queue model of the list kept here, or against the table's result where a row gives one.
// Depends on odt_pkg and ordered_deque_table.
`timescale 1ns / 1ps

module tb_ordered_deque_table;
  import odt_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam int RANDOM_OPS = 400;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  // One row of the directed table: the operation and, where obvious, its result
  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } op_row_t;

  localparam out_beat_t NO_RESULT   = '0;
  localparam out_beat_t EMPTY_RES   = '{-32'sd1, STATUS_EMPTY, 5'd0, 1'b1, 1'b0};
  localparam out_beat_t FULL_RES    = '{32'sd0, STATUS_FULL, 5'd16, 1'b0, 1'b1};
  localparam out_beat_t MISSING_RES = '{32'sd0, STATUS_NOT_FOUND, 5'd16, 1'b0, 1'b1};

  localparam int N_DIRECTED = 25;
  localparam op_row_t DIRECTED_OPS [N_DIRECTED] = '{
    // every removal and lookup on the empty list
    '{'{MODE_POP_FRONT,  32'sd0},         1'b1, EMPTY_RES},
    '{'{MODE_POP_BACK,   -32'sd1},        1'b1, EMPTY_RES},
    '{'{MODE_PEEK_FRONT, WORD_MAX},       1'b1, EMPTY_RES},
    '{'{MODE_PEEK_BACK,  WORD_MIN},       1'b1, EMPTY_RES},
    '{'{MODE_DELETE,     32'sd0},         1'b1, EMPTY_RES},
    // fill to capacity: adds at both ends and ordered inserts at front, back and before an equal word
    '{'{MODE_INSERT,     32'sd0},         1'b0, NO_RESULT},
    '{'{MODE_INSERT,     WORD_MIN},       1'b0, NO_RESULT},
    '{'{MODE_INSERT,     WORD_MAX},       1'b0, NO_RESULT},
    '{'{MODE_INSERT,     32'sd0},         1'b0, NO_RESULT},
    '{'{MODE_ADD_FRONT,  WORD_MAX},       1'b0, NO_RESULT},
    '{'{MODE_ADD_BACK,   WORD_MIN},       1'b0, NO_RESULT},
    '{'{MODE_INSERT,     -32'sd1},        1'b0, NO_RESULT},
    '{'{MODE_ADD_FRONT,  32'sd1},         1'b0, NO_RESULT},
    '{'{MODE_ADD_BACK,   32'sd1},         1'b0, NO_RESULT},
    '{'{MODE_INSERT,     32'sd1},         1'b0, NO_RESULT},
    '{'{MODE_INSERT,     WORD_MAX},       1'b0, NO_RESULT},
    '{'{MODE_ADD_FRONT,  -32'sd1},        1'b0, NO_RESULT},
    '{'{MODE_ADD_BACK,   32'sh5555_5555}, 1'b0, NO_RESULT},
    '{'{MODE_INSERT,     32'sh2AAA_AAAA}, 1'b0, NO_RESULT},
    '{'{MODE_ADD_FRONT,  32'shAAAA_AAAA}, 1'b0, NO_RESULT},
    '{'{MODE_ADD_BACK,   32'sh1234_5678}, 1'b0, NO_RESULT},
    // full list: every add is refused, a missing word is not found
    '{'{MODE_ADD_FRONT,  32'sd0},         1'b1, FULL_RES},
    '{'{MODE_ADD_BACK,   32'sd0},         1'b1, FULL_RES},
    '{'{MODE_INSERT,     WORD_MIN},       1'b1, FULL_RES},
    '{'{MODE_DELETE,     32'sh0BAD_F00D}, 1'b1, MISSING_RES}
  };

  localparam mode_t GROW_OPS [3]   = '{MODE_ADD_FRONT, MODE_ADD_BACK, MODE_INSERT};
  localparam mode_t SHRINK_OPS [3] = '{MODE_POP_FRONT, MODE_POP_BACK, MODE_DELETE};
  localparam mode_t PEEK_OPS [2]   = '{MODE_PEEK_FRONT, MODE_PEEK_BACK};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  logic signed [31:0] list_words [$];
  out_beat_t          due_results [$];
  out_beat_t          head_result;
  int                 fails = 0;
  bit                 calm = 1'b0;

  ordered_deque_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the list model and return the result it gives
  function automatic out_beat_t apply_list_op(input in_beat_t beat);
    out_beat_t          r;
    logic signed [31:0] word;
    int                 pos;
    r    = '0;
    word = $signed(beat.value);
    r.status = STATUS_OK;
    case (beat.mode)
      MODE_ADD_FRONT, MODE_ADD_BACK, MODE_INSERT: begin
        if (list_words.size() >= DEPTH) begin
          r.status = STATUS_FULL;
        end else if (beat.mode == MODE_ADD_FRONT) begin
          list_words.push_front(word);
        end else if (beat.mode == MODE_ADD_BACK) begin
          list_words.push_back(word);
        end else begin
          pos = 0;
          while (pos < list_words.size() && list_words[pos] < word) pos++;
          list_words.insert(pos, word);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (list_words.size() == 0) begin
          r.value_out = -32'sd1;
          r.status    = STATUS_EMPTY;
        end else if (beat.mode == MODE_POP_FRONT) begin
          r.value_out = list_words.pop_front();
        end else if (beat.mode == MODE_POP_BACK) begin
          r.value_out = list_words.pop_back();
        end else if (beat.mode == MODE_PEEK_FRONT) begin
          r.value_out = list_words[0];
        end else begin
          r.value_out = list_words[list_words.size() - 1];
        end
      end
      default: begin
        if (list_words.size() == 0) begin
          r.value_out = -32'sd1;
          r.status    = STATUS_EMPTY;
        end else begin
          pos = 0;
          while (pos < list_words.size() && list_words[pos] != word) pos++;
          if (pos == list_words.size()) begin
            r.status = STATUS_NOT_FOUND;
          end else begin
            r.value_out = list_words[pos];
            list_words.delete(pos);
          end
        end
      end
    endcase
    r.entries  = 5'(list_words.size());
    r.is_empty = (list_words.size() == 0);
    r.is_full  = (list_words.size() >= DEPTH);
    return r;
  endfunction

  // Offer one operation beat, hold it until taken, then record its result
  task automatic send_op(input in_beat_t beat, input logic typed, input out_beat_t typed_res);
    out_beat_t predicted;
    if (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(beat);
    due_results.push_back(typed ? typed_res : predicted);
  endtask

  // Stimulus: reset, directed table, random operations, drain
  initial begin : stimulus
    in_beat_t beat;
    int       roll;
    bit       filling;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_op(DIRECTED_OPS[k].beat, DIRECTED_OPS[k].typed, DIRECTED_OPS[k].want);
    end

    // Drift between filling and draining so both ends of the list are reached often
    filling = 1'b0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm = (n >= 150 && n < 250);
      if (list_words.size() >= DEPTH) filling = 1'b0;
      if (list_words.size() == 0) filling = 1'b1;
      roll = $urandom_range(99);
      if (roll < 10) begin
        beat.mode = mode_t'($urandom_range(7));
      end else if (roll < 70) begin
        beat.mode = filling ? GROW_OPS[$urandom_range(2)] : SHRINK_OPS[$urandom_range(2)];
      end else if (roll < 85) begin
        beat.mode = filling ? SHRINK_OPS[$urandom_range(2)] : GROW_OPS[$urandom_range(2)];
      end else begin
        beat.mode = PEEK_OPS[$urandom_range(1)];
      end
      // small values give duplicates and delete hits; wide ones toggle every bit
      if ($urandom_range(3) == 0) beat.value = $urandom();
      else beat.value = $signed(32'($urandom_range(8))) - 32'sd4;
      if (beat.mode == MODE_DELETE && list_words.size() != 0 && $urandom_range(9) < 7) begin
        beat.value = list_words[$urandom_range(list_words.size() - 1)];
      end
      send_op(beat, 1'b0, NO_RESULT);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Check each result beat against the oldest expectation, then choose the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result beat with no operation waiting");
        fails++;
      end else begin
        head_result = due_results.pop_front();
        if (out_data.value_out !== head_result.value_out) begin
          $error("value_out: expected %0d, got %0d", head_result.value_out, out_data.value_out);
          fails++;
        end
        if (out_data.status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, out_data.status);
          fails++;
        end
        if (out_data.entries !== head_result.entries) begin
          $error("entries: expected %0d, got %0d", head_result.entries, out_data.entries);
          fails++;
        end
        if (out_data.is_empty !== head_result.is_empty) begin
          $error("is_empty: expected %0b, got %0b", head_result.is_empty, out_data.is_empty);
          fails++;
        end
        if (out_data.is_full !== head_result.is_full) begin
          $error("is_full: expected %0b, got %0b", head_result.is_full, out_data.is_full);
          fails++;
        end
      end
    end
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Hard stop in case the handshake hangs
  initial begin
    #(2_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
